// ===== src/hsc_pkg.sv =====
// Shared types, constants and the commutation table of the hall six-step commutator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

    // Field widths fixed by the stream format
    localparam int HALL_WIDTH   = 3;
    localparam int DUTY_WIDTH   = 16;
    localparam int COUNT_WIDTH  = 32;
    localparam int TIMER_WIDTH_DEFAULT = 32;

    // Gate order: high A, low A, high B, low B, high C, low C
    localparam int GATE_COUNT   = 6;
    localparam int GATE_IDX_W   = $clog2(GATE_COUNT);

    localparam logic [GATE_IDX_W-1:0] GATE_HIGH_A = GATE_IDX_W'(0);
    localparam logic [GATE_IDX_W-1:0] GATE_LOW_A  = GATE_IDX_W'(1);
    localparam logic [GATE_IDX_W-1:0] GATE_HIGH_B = GATE_IDX_W'(2);
    localparam logic [GATE_IDX_W-1:0] GATE_LOW_B  = GATE_IDX_W'(3);
    localparam logic [GATE_IDX_W-1:0] GATE_HIGH_C = GATE_IDX_W'(4);
    localparam logic [GATE_IDX_W-1:0] GATE_LOW_C  = GATE_IDX_W'(5);

    // Hall codes
    localparam logic [HALL_WIDTH-1:0] HALL_1 = 3'd1;
    localparam logic [HALL_WIDTH-1:0] HALL_2 = 3'd2;
    localparam logic [HALL_WIDTH-1:0] HALL_3 = 3'd3;
    localparam logic [HALL_WIDTH-1:0] HALL_4 = 3'd4;
    localparam logic [HALL_WIDTH-1:0] HALL_5 = 3'd5;
    localparam logic [HALL_WIDTH-1:0] HALL_6 = 3'd6;

    typedef logic [GATE_COUNT-1:0][DUTY_WIDTH-1:0] gate_array_t;

    // One commutation step: which high and low gate to energize
    typedef struct packed {
        logic                  valid;
        logic [GATE_IDX_W-1:0] high;
        logic [GATE_IDX_W-1:0] low;
    } comm_t;

    // Edge and interval status carried to the result word
    typedef struct packed {
        logic                   edge_seen;
        logic [COUNT_WIDTH-1:0] edges_total;
        logic [COUNT_WIDTH-1:0] ticks_total;
    } timer_stat_t;

    // Commutation table by direction and hall code; 000 and 111 have no step
    function automatic comm_t comm_lookup(input logic reverse,
                                          input logic [HALL_WIDTH-1:0] hall);
        comm_t c;
        c = '{valid: 1'b1, high: GATE_HIGH_A, low: GATE_LOW_A};
        if (!reverse)
        begin
            unique case (hall)
                HALL_1:  begin c.high = GATE_HIGH_C; c.low = GATE_LOW_B; end
                HALL_2:  begin c.high = GATE_HIGH_B; c.low = GATE_LOW_A; end
                HALL_3:  begin c.high = GATE_HIGH_C; c.low = GATE_LOW_A; end
                HALL_4:  begin c.high = GATE_HIGH_A; c.low = GATE_LOW_C; end
                HALL_5:  begin c.high = GATE_HIGH_A; c.low = GATE_LOW_B; end
                HALL_6:  begin c.high = GATE_HIGH_B; c.low = GATE_LOW_C; end
                default: c.valid = 1'b0;
            endcase
        end
        else
        begin
            unique case (hall)
                HALL_1:  begin c.high = GATE_HIGH_B; c.low = GATE_LOW_C; end
                HALL_2:  begin c.high = GATE_HIGH_A; c.low = GATE_LOW_B; end
                HALL_3:  begin c.high = GATE_HIGH_A; c.low = GATE_LOW_C; end
                HALL_4:  begin c.high = GATE_HIGH_C; c.low = GATE_LOW_A; end
                HALL_5:  begin c.high = GATE_HIGH_B; c.low = GATE_LOW_A; end
                HALL_6:  begin c.high = GATE_HIGH_C; c.low = GATE_LOW_B; end
                default: c.valid = 1'b0;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/hsc_edge_timer.sv =====
// Hall edge detector with interval timer, edge counter and interval total.
// Depends on hsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsc_edge_timer
    import hsc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [HALL_WIDTH-1:0] hall_code,
    output timer_stat_t                stat_next
);

    logic [HALL_WIDTH-1:0]  prev_hall_reg;
    logic [TIMER_WIDTH-1:0] interval_reg;
    logic [COUNT_WIDTH-1:0] edge_count_reg;
    logic [COUNT_WIDTH-1:0] interval_sum_reg;

    logic                   edge_det;
    logic [TIMER_WIDTH-1:0] interval_inc;
    logic [COUNT_WIDTH-1:0] interval_ext;
    logic [TIMER_WIDTH-1:0] interval_next;

    // Count this tick, then capture on a hall change
    assign edge_det      = (hall_code != prev_hall_reg);
    assign interval_inc  = interval_reg + TIMER_WIDTH'(1);
    assign interval_next = edge_det ? '0 : interval_inc;

    // Fit the interval to the total's width
    generate
        if (TIMER_WIDTH >= COUNT_WIDTH)
        begin : g_trunc
            assign interval_ext = interval_inc[COUNT_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign interval_ext = {{(COUNT_WIDTH-TIMER_WIDTH){1'b0}}, interval_inc};
        end
    endgenerate

    always_comb
    begin
        stat_next.edge_seen   = edge_det;
        stat_next.edges_total = edge_det ? edge_count_reg + COUNT_WIDTH'(1)
                                         : edge_count_reg;
        stat_next.ticks_total = edge_det ? interval_sum_reg + interval_ext
                                         : interval_sum_reg;
    end

    // Advance state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hall_reg    <= '0;
            interval_reg     <= '0;
            edge_count_reg   <= '0;
            interval_sum_reg <= '0;
        end
        else if (step)
        begin
            prev_hall_reg    <= hall_code;
            interval_reg     <= interval_next;
            edge_count_reg   <= stat_next.edges_total;
            interval_sum_reg <= stat_next.ticks_total;
        end
    end

endmodule

`default_nettype wire

// ===== src/hsc_gate_drive.sv =====
// Commutation table lookup and the six held gate duties.
// Depends on hsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsc_gate_drive
    import hsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [HALL_WIDTH-1:0] hall_code,
    input  wire logic                  reverse,
    input  wire logic [DUTY_WIDTH-1:0] duty,
    output gate_array_t                gate_next
);

    gate_array_t gate_reg;
    comm_t       comm;

    assign comm = comm_lookup(reverse, hall_code);

    // Energize one high and one low gate; hold on invalid hall codes
    always_comb
    begin
        gate_next = gate_reg;
        if (comm.valid)
        begin
            for (int g = 0; g < GATE_COUNT; g++)
            begin
                if (GATE_IDX_W'(g) == comm.high || GATE_IDX_W'(g) == comm.low)
                    gate_next[g] = duty;
                else
                    gate_next[g] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gate_reg <= '0;
        else if (step)
            gate_reg <= gate_next;
    end

endmodule

`default_nettype wire

// ===== src/hall_six_step_commutator.sv =====
// Hall six-step commutator: one input word per time-base tick, one result word each.
// Registers: an input register, then the result register, with single-pass logic between.
// Throughput: one word per cycle while the result side is not stalled by m_axis_tready.
// Reset: asynchronous active-low; clears hall history, counters and gate duties to zero.
// Depends on hsc_pkg, hsc_edge_timer and hsc_gate_drive.
`timescale 1ns / 1ps
`default_nettype none

module hall_six_step_commutator
    import hsc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // hall_code[2:0], reverse[3], duty[19:4], zero pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [167:0]      m_axis_tdata    // gate_high_a, gate_low_a, gate_high_b,
                                              // gate_low_b, gate_high_c, gate_low_c (16 each),
                                              // edge_seen[96], edges_total[128:97],
                                              // ticks_total[160:129], zero pad
);

    localparam int OUT_USED = GATE_COUNT*DUTY_WIDTH + 1 + 2*COUNT_WIDTH;

    logic                  in_valid_reg;
    logic [HALL_WIDTH-1:0] in_hall_reg;
    logic                  in_reverse_reg;
    logic [DUTY_WIDTH-1:0] in_duty_reg;

    logic                  out_valid_reg;
    gate_array_t           out_gate_reg;
    timer_stat_t           out_stat_reg;

    logic                  advance;
    gate_array_t           gate_next;
    timer_stat_t           stat_next;

    // Move the held word on when the result register is free or drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_hall_reg    <= s_axis_tdata[HALL_WIDTH-1:0];
            in_reverse_reg <= s_axis_tdata[HALL_WIDTH];
            in_duty_reg    <= s_axis_tdata[HALL_WIDTH+DUTY_WIDTH:HALL_WIDTH+1];
        end
    end

    hsc_edge_timer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_edge_timer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_valid_reg && advance),
        .hall_code (in_hall_reg),
        .stat_next (stat_next)
    );

    hsc_gate_drive u_gate_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_valid_reg && advance),
        .hall_code (in_hall_reg),
        .reverse   (in_reverse_reg),
        .duty      (in_duty_reg),
        .gate_next (gate_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_gate_reg <= gate_next;
            out_stat_reg <= stat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(168-OUT_USED){1'b0}},
                            out_stat_reg.ticks_total,
                            out_stat_reg.edges_total,
                            out_stat_reg.edge_seen,
                            out_gate_reg};

endmodule

`default_nettype wire

// ===== tb/sv/hsc_result_checker.sv =====
// Scoreboard for the hall six-step commutator: predicts each result word from the accepted
// input words and compares it with what leaves the block. Depends on hsc_pkg only.
`timescale 1ns / 1ps

module hsc_result_checker
    import hsc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // hall_code[2:0], reverse[3], duty[19:4], zero pad
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [167:0] m_axis_tdata,   // six gate duties (16 each), edge_seen[96],
                                              // edges_total[128:97], ticks_total[160:129]
    output int                mismatch_count,
    output int                pending_count
);

    // One predicted result word
    typedef struct packed {
        gate_array_t            gates;
        logic                   edge_seen;
        logic [COUNT_WIDTH-1:0] edges_total;
        logic [COUNT_WIDTH-1:0] ticks_total;
    } commutation_t;

    // Predictor state
    logic [HALL_WIDTH-1:0]          last_hall;
    logic [TIMER_WIDTH_DEFAULT-1:0] ticks_since_change;
    logic [COUNT_WIDTH-1:0]         interval_total;
    logic [COUNT_WIDTH-1:0]         hall_changes;
    gate_array_t                    gate_state;

    commutation_t commutation_q[$];
    commutation_t want;
    commutation_t got;

    string gate_name [GATE_COUNT] = '{"gate_high_a", "gate_low_a", "gate_high_b",
                                      "gate_low_b", "gate_high_c", "gate_low_c"};

    // Six-step table: returns 0 for codes with no step
    function automatic logic step_gates(input logic rev, input logic [HALL_WIDTH-1:0] hall,
                                        output logic [GATE_IDX_W-1:0] hi,
                                        output logic [GATE_IDX_W-1:0] lo);
        hi = GATE_HIGH_A;
        lo = GATE_LOW_A;
        case ({rev, hall})
            {1'b0, HALL_1}: begin hi = GATE_HIGH_C; lo = GATE_LOW_B; end
            {1'b0, HALL_2}: begin hi = GATE_HIGH_B; lo = GATE_LOW_A; end
            {1'b0, HALL_3}: begin hi = GATE_HIGH_C; lo = GATE_LOW_A; end
            {1'b0, HALL_4}: begin hi = GATE_HIGH_A; lo = GATE_LOW_C; end
            {1'b0, HALL_5}: begin hi = GATE_HIGH_A; lo = GATE_LOW_B; end
            {1'b0, HALL_6}: begin hi = GATE_HIGH_B; lo = GATE_LOW_C; end
            {1'b1, HALL_1}: begin hi = GATE_HIGH_B; lo = GATE_LOW_C; end
            {1'b1, HALL_2}: begin hi = GATE_HIGH_A; lo = GATE_LOW_B; end
            {1'b1, HALL_3}: begin hi = GATE_HIGH_A; lo = GATE_LOW_C; end
            {1'b1, HALL_4}: begin hi = GATE_HIGH_C; lo = GATE_LOW_A; end
            {1'b1, HALL_5}: begin hi = GATE_HIGH_B; lo = GATE_LOW_A; end
            {1'b1, HALL_6}: begin hi = GATE_HIGH_C; lo = GATE_LOW_B; end
            default:        return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Advance the predictor by one tick and return the result word it produces
    function automatic commutation_t commutate_tick(input logic [HALL_WIDTH-1:0] hall,
                                                    input logic rev,
                                                    input logic [DUTY_WIDTH-1:0] duty);
        commutation_t r;
        logic [GATE_IDX_W-1:0] hi;
        logic [GATE_IDX_W-1:0] lo;
        logic changed;
        changed = (hall != last_hall);
        ticks_since_change = ticks_since_change + 1'b1;
        if (changed)
        begin
            hall_changes = hall_changes + 1'b1;
            interval_total = interval_total + ticks_since_change[COUNT_WIDTH-1:0];
            ticks_since_change = '0;
        end
        last_hall = hall;
        // Invalid codes hold the previous duties
        if (step_gates(rev, hall, hi, lo))
        begin
            gate_state = '0;
            gate_state[hi] = duty;
            gate_state[lo] = duty;
        end
        r.gates = gate_state;
        r.edge_seen = changed;
        r.edges_total = hall_changes;
        r.ticks_total = interval_total;
        return r;
    endfunction

    // Predict on every accepted input word, compare on every accepted result word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hall = '0;
            ticks_since_change = '0;
            interval_total = '0;
            hall_changes = '0;
            gate_state = '0;
            commutation_q.delete();
            mismatch_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                commutation_q.push_back(commutate_tick(s_axis_tdata[2:0], s_axis_tdata[3],
                                                       s_axis_tdata[19:4]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.gates = m_axis_tdata[95:0];
                got.edge_seen = m_axis_tdata[96];
                got.edges_total = m_axis_tdata[128:97];
                got.ticks_total = m_axis_tdata[160:129];
                if (commutation_q.size() == 0)
                begin
                    $error("result word with nothing predicted: %h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = commutation_q.pop_front();
                    for (int g = 0; g < GATE_COUNT; g++)
                        if (got.gates[g] !== want.gates[g])
                        begin
                            $error("%s: expected %h, got %h", gate_name[g],
                                   want.gates[g], got.gates[g]);
                            mismatch_count++;
                        end
                    if (got.edge_seen !== want.edge_seen)
                    begin
                        $error("edge_seen: expected %b, got %b", want.edge_seen, got.edge_seen);
                        mismatch_count++;
                    end
                    if (got.edges_total !== want.edges_total)
                    begin
                        $error("edges_total: expected %0d, got %0d",
                               want.edges_total, got.edges_total);
                        mismatch_count++;
                    end
                    if (got.ticks_total !== want.ticks_total)
                    begin
                        $error("ticks_total: expected %0d, got %0d",
                               want.ticks_total, got.ticks_total);
                        mismatch_count++;
                    end
                end
            end
            pending_count = commutation_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the commutator testbench: clock, reset, tick stimulus and output back-pressure.
// Instantiates hall_six_step_commutator and hsc_result_checker; depends on hsc_pkg.
`timescale 1ns / 1ps

module tb_top
    import hsc_pkg::*;
();

    localparam int RANDOM_TICKS = 1050;

    // Hall codes with no commutation step
    localparam logic [HALL_WIDTH-1:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [HALL_WIDTH-1:0] HALL_ALL_HIGH = 3'd7;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;   // hall_code[2:0], reverse[3], duty[19:4], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;        // six gate duties (16 each), edge_seen[96],
                                       // edges_total[128:97], ticks_total[160:129]

    int mismatch_count;
    int pending_count;
    int ticks_sent = 0;
    int cycle_count = 0;

    always #10 clk = ~clk;

    hall_six_step_commutator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hsc_result_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Stall the result side at random about 12 percent of the time, never inside the quiet window
    always @(negedge clk)
    begin
        cycle_count <= cycle_count + 1;
        m_axis_tready <= (cycle_count >= 600 && cycle_count < 900) ||
                         ($urandom_range(0, 99) >= 12);
    end

    // Present one tick word, with random gaps outside the quiet window
    task automatic send_tick(input logic [HALL_WIDTH-1:0] hall, input logic rev,
                             input logic [DUTY_WIDTH-1:0] duty);
        while (!(ticks_sent >= 400 && ticks_sent < 650) && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, duty, rev, hall};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Position along the one-bit-change hall sequence
    function automatic logic [HALL_WIDTH-1:0] rotor_code(input int pos);
        case (pos % 6)
            0:       return HALL_5;
            1:       return HALL_4;
            2:       return HALL_6;
            3:       return HALL_2;
            4:       return HALL_3;
            default: return HALL_1;
        endcase
    endfunction

    // Duty with extra weight on the extremes
    function automatic logic [DUTY_WIDTH-1:0] pick_duty();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return DUTY_WIDTH'($urandom);
    endfunction

    initial
    begin
        int base_ticks;
        int pos;
        int steps;
        int dwell;
        int wait_cycles;
        logic rev;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: invalid code right after reset, then first edge from reset state
        send_tick(HALL_ALL_LOW, 1'b0, 16'h1234);
        send_tick(HALL_5, 1'b0, 16'hFFFF);
        send_tick(HALL_5, 1'b0, 16'h0000);
        // Every code in each direction, along the rotation order
        for (int i = 1; i < 6; i++)
            send_tick(rotor_code(i), 1'b0, 16'hAAAA ^ 16'(i));
        for (int i = 5; i >= 0; i--)
            send_tick(rotor_code(i), 1'b1, 16'h5555 + 16'(i));
        // Invalid codes hold the duties but still count edges
        send_tick(HALL_ALL_HIGH, 1'b0, 16'hFFFF);
        send_tick(HALL_ALL_HIGH, 1'b1, 16'h0001);
        send_tick(HALL_ALL_LOW, 1'b1, 16'h8000);
        // Direction flip on the same code, then duty extremes
        send_tick(HALL_3, 1'b1, 16'h0001);
        send_tick(HALL_3, 1'b0, 16'h8000);
        send_tick(HALL_6, 1'b0, 16'hFFFF);
        send_tick(HALL_6, 1'b1, 16'h0000);

        // Random: mostly clean rotation with random dwell, some noise
        base_ticks = ticks_sent;
        while (ticks_sent - base_ticks < RANDOM_TICKS)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                rev = 1'($urandom_range(0, 1));
                pos = $urandom_range(0, 5);
                steps = $urandom_range(6, 24);
                for (int s = 0; s < steps; s++)
                begin
                    dwell = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
                    repeat (dwell)
                        send_tick(rotor_code(pos), rev, pick_duty());
                    pos = rev ? pos + 5 : pos + 1;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    send_tick(HALL_WIDTH'($urandom), 1'($urandom), pick_duty());
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for the pipeline depth
        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 5000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== hall_six_step_commutator.f =====
src/hsc_pkg.sv
src/hsc_edge_timer.sv
src/hsc_gate_drive.sv
src/hall_six_step_commutator.sv
tb/sv/hsc_result_checker.sv
tb/sv/tb_top.sv
